@@ hdl/cba_pkg.sv @@
package cba_pkg;

  // Store geometry
  localparam int NUM_BLOCKS = 64;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);

  // Field widths
  localparam int TAG_W   = 10;
  localparam int OWNER_W = 8;
  localparam int SIZE_W  = 7;
  localparam int START_W = 6;
  localparam int RND_W   = 8;
  localparam int LIM_W   = ((IDX_W > RND_W) ? IDX_W : RND_W) + 1;

  // Tag codes
  localparam logic [TAG_W-1:0] TAG_EMPTY   = 10'h3FF;
  localparam logic [TAG_W-1:0] TAG_PADDING = 10'h3FE;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_e;

  // Smallest power of two not below n, zero for zero
  function automatic logic [RND_W-1:0] round_pow2(input logic [SIZE_W-1:0] n);
    logic [RND_W-1:0] r;
    r = '0;
    for (int k = RND_W - 1; k >= 0; k--) begin
      if (RND_W'(n) <= (RND_W'(1) << k)) begin
        r = RND_W'(1) << k;
      end
    end
    if (n == '0) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

@@ hdl/cba_if.sv @@
interface cba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [cba_pkg::OWNER_W-1:0]  owner_id;
  logic [cba_pkg::SIZE_W-1:0]   request_size;
  logic [cba_pkg::START_W-1:0]  start_block;

  modport source (output valid, operation, owner_id, request_size, start_block,
                  input ready);
  modport sink   (input valid, operation, owner_id, request_size, start_block,
                  output ready);
endinterface

interface cba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [cba_pkg::SIZE_W-1:0] rounded_blocks;

  modport source (output valid, status, rounded_blocks, input ready);
  modport sink   (input valid, status, rounded_blocks, output ready);
endinterface

@@ hdl/contiguous_block_allocator.sv @@
// A request is taken only in idle; the tag ring then rotates once through the scan state to
// check or search and once more through the write state, one tag through the head cell per
// cycle, before the response state loads the output register and the block returns to idle.
// A finished response waits in the output register while the next request is taken.
// Reset: asynchronous, active low; every tag reads empty, no response pending.
module contiguous_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  cba_req_if.sink       req_i,
  cba_rsp_if.source     rsp_o
);

  logic [cba_pkg::TAG_W-1:0] tags [cba_pkg::NUM_BLOCKS];
  logic [cba_pkg::TAG_W-1:0] new_tag;
  logic                      shift;

  cba_pkg::state_e                state_q, state_d;
  logic [cba_pkg::IDX_W-1:0]      idx_q, idx_d;
  cba_pkg::op_e                   op_q, op_d;
  logic [cba_pkg::OWNER_W-1:0]    owner_q, owner_d;
  logic [cba_pkg::SIZE_W-1:0]     size_q, size_d;
  logic [cba_pkg::START_W-1:0]    start_q, start_d;
  logic [cba_pkg::RND_W-1:0]      rnd_q, rnd_d;
  logic                           ok_q, ok_d;
  logic                           found_q, found_d;
  logic [cba_pkg::IDX_W-1:0]      first_q, first_d;
  logic                           out_valid_q, out_valid_d;
  cba_pkg::status_e               out_status_q, out_status_d;
  logic [cba_pkg::SIZE_W-1:0]     out_rnd_q, out_rnd_d;

  logic [cba_pkg::RND_W-1:0]      req_rnd;
  logic [cba_pkg::LIM_W-1:0]      req_end;
  logic [cba_pkg::LIM_W-1:0]      idx_ext;
  logic [cba_pkg::LIM_W-1:0]      start_ext;
  logic [cba_pkg::LIM_W-1:0]      first_ext;
  logic [cba_pkg::LIM_W-1:0]      alloc_end;
  logic [cba_pkg::LIM_W-1:0]      owner_end;
  logic [cba_pkg::LIM_W-1:0]      free_end;
  logic                           in_alloc;
  logic                           in_free;
  logic                           last_idx;
  logic                           accept;

  // Ring of tag cells: cell 0 is the head, the updated head tag re-enters at the tail
  for (genvar g = 0; g < cba_pkg::NUM_BLOCKS; g++) begin : g_cell
    logic [cba_pkg::TAG_W-1:0] link;
    if (g == cba_pkg::NUM_BLOCKS - 1) begin : g_tail
      assign link = new_tag;
    end else begin : g_mid
      assign link = tags[g+1];
    end
    cba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .tag_i   (link),
      .tag_o   (tags[g])
    );
  end

  // Range arithmetic on the block index now at the head
  assign req_rnd   = cba_pkg::round_pow2(req_i.request_size);
  assign req_end   = cba_pkg::LIM_W'(req_i.start_block) + cba_pkg::LIM_W'(req_rnd);
  assign idx_ext   = cba_pkg::LIM_W'(idx_q);
  assign start_ext = cba_pkg::LIM_W'(start_q);
  assign first_ext = cba_pkg::LIM_W'(first_q);
  assign alloc_end = start_ext + cba_pkg::LIM_W'(rnd_q);
  assign owner_end = start_ext + cba_pkg::LIM_W'(size_q);
  assign free_end  = first_ext + cba_pkg::LIM_W'(rnd_q);
  assign in_alloc  = (idx_ext >= start_ext) && (idx_ext < alloc_end);
  assign in_free   = (idx_ext >= first_ext) && (idx_ext < free_end);
  assign last_idx  = (idx_q == cba_pkg::IDX_W'(cba_pkg::NUM_BLOCKS - 1));
  assign accept    = req_i.valid && req_i.ready;

  assign req_i.ready = (state_q == cba_pkg::S_IDLE);
  assign shift       = (state_q == cba_pkg::S_SCAN) || (state_q == cba_pkg::S_WRITE);

  // Sequence the check pass, the write pass and the response
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    op_d         = op_q;
    owner_d      = owner_q;
    size_d       = size_q;
    start_d      = start_q;
    rnd_d        = rnd_q;
    ok_d         = ok_q;
    found_d      = found_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_rnd_d    = out_rnd_q;
    new_tag      = tags[0];

    // Drop the response once taken
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cba_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = cba_pkg::op_e'(req_i.operation);
          owner_d = req_i.owner_id;
          size_d  = req_i.request_size;
          start_d = req_i.start_block;
          rnd_d   = req_rnd;
          ok_d    = (cba_pkg::LIM_W'(req_i.start_block) < cba_pkg::LIM_W'(cba_pkg::NUM_BLOCKS))
                 && (req_end <= cba_pkg::LIM_W'(cba_pkg::NUM_BLOCKS));
          found_d = 1'b0;
          first_d = '0;
          idx_d   = '0;
          state_d = cba_pkg::S_SCAN;
        end
      end
      cba_pkg::S_SCAN: begin
        // Check the range on allocate, find the owner's first block on free
        if (op_q == cba_pkg::OP_ALLOC) begin
          if (in_alloc && tags[0] != cba_pkg::TAG_EMPTY) begin
            ok_d = 1'b0;
          end
        end else if (!found_q && tags[0] == cba_pkg::TAG_W'(owner_q)) begin
          found_d = 1'b1;
          first_d = idx_q;
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = cba_pkg::S_WRITE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      cba_pkg::S_WRITE: begin
        // Rewrite the head tag as it passes
        if (op_q == cba_pkg::OP_ALLOC) begin
          if (ok_q && in_alloc) begin
            new_tag = (idx_ext < owner_end) ? cba_pkg::TAG_W'(owner_q)
                                            : cba_pkg::TAG_PADDING;
          end
        end else if (found_q && in_free) begin
          new_tag = cba_pkg::TAG_EMPTY;
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = cba_pkg::S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      cba_pkg::S_RESP: begin
        // Load the output register once it is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_rnd_d   = rnd_q[cba_pkg::SIZE_W-1:0];
          if (op_q == cba_pkg::OP_ALLOC) begin
            out_status_d = ok_q ? cba_pkg::ST_DONE : cba_pkg::ST_NO_SPACE;
          end else begin
            out_status_d = found_q ? cba_pkg::ST_DONE : cba_pkg::ST_NOT_FOUND;
          end
          state_d = cba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cba_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cba_pkg::S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    owner_q      <= owner_d;
    size_q       <= size_d;
    start_q      <= start_d;
    rnd_q        <= rnd_d;
    ok_q         <= ok_d;
    found_q      <= found_d;
    first_q      <= first_d;
    out_status_q <= out_status_d;
    out_rnd_q    <= out_rnd_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.rounded_blocks = out_rnd_q;

  // Ring is aligned with block 0 at the head whenever the block is idle
  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cba_pkg::S_IDLE) |-> (idx_q == '0))
    else $error("tag ring out of alignment while idle");

  // A new response only comes out of the response state
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cba_pkg::S_RESP))
    else $error("response raised outside the response state");

  // Hold the response steady while the receiver stalls
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=>
      (out_valid_q && $stable(out_status_q) && $stable(out_rnd_q)))
    else $error("response changed while stalled");

endmodule

@@ hdl/cba_cell.sv @@
module cba_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic [cba_pkg::TAG_W-1:0] tag_i,
  output logic [cba_pkg::TAG_W-1:0] tag_o
);

  logic [cba_pkg::TAG_W-1:0] tag_q;

  // Hold one block tag, take the neighbor's tag on shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= cba_pkg::TAG_EMPTY;
    end else if (shift_i) begin
      tag_q <= tag_i;
    end
  end

  assign tag_o = tag_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    cba_pkg::op_e                 op;
    logic [cba_pkg::OWNER_W-1:0]  owner;
    logic [cba_pkg::SIZE_W-1:0]   size;
    logic [cba_pkg::START_W-1:0]  start;
  } request_t;

  typedef struct packed {
    cba_pkg::status_e             status;
    logic [cba_pkg::SIZE_W-1:0]   rounded;
  } rsp_t;

  typedef struct packed {
    logic [cba_pkg::OWNER_W-1:0]  owner;
    logic [cba_pkg::SIZE_W-1:0]   size;
  } lease_t;

  localparam int LATENCY = 2 * cba_pkg::NUM_BLOCKS + 2;

  logic clk_i = 1'b0;
  logic rst_ni;

  cba_req_if req_if ();
  cba_rsp_if rsp_if ();

  contiguous_block_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirror of the tag store, expected responses and live allocations
  logic [cba_pkg::TAG_W-1:0] tag_store [cba_pkg::NUM_BLOCKS];
  rsp_t             expected_rsp_q [$];
  lease_t           lease_q [$];
  int               error_count = 0;
  int               send_idle_pct = 0;
  int               rsp_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  // Smallest power of two not below n, zero for zero
  function automatic int pow2_ceil(int n);
    int r;
    r = 1;
    if (n == 0) begin
      return 0;
    end
    while (r < n) begin
      r = r << 1;
    end
    return r;
  endfunction

  function automatic bit range_empty(int first, int count);
    if (first + count > cba_pkg::NUM_BLOCKS) begin
      return 1'b0;
    end
    for (int i = first; i < first + count; i++) begin
      if (tag_store[i] != cba_pkg::TAG_EMPTY) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Apply one request to the mirrored store and return its response
  function automatic rsp_t apply_request(request_t rq);
    rsp_t r;
    int   rnd;
    int   first;
    int   stop;
    rnd       = pow2_ceil(rq.size);
    r.rounded = cba_pkg::SIZE_W'(rnd);
    if (rq.op == cba_pkg::OP_ALLOC) begin
      if (range_empty(rq.start, rnd)) begin
        for (int i = 0; i < rnd; i++) begin
          tag_store[rq.start + i] = (i < rq.size) ? cba_pkg::TAG_W'(rq.owner)
                                                  : cba_pkg::TAG_PADDING;
        end
        r.status = cba_pkg::ST_DONE;
      end else begin
        r.status = cba_pkg::ST_NO_SPACE;
      end
    end else begin
      first = -1;
      for (int i = cba_pkg::NUM_BLOCKS - 1; i >= 0; i--) begin
        if (tag_store[i] == cba_pkg::TAG_W'(rq.owner)) begin
          first = i;
        end
      end
      if (first < 0) begin
        r.status = cba_pkg::ST_NOT_FOUND;
      end else begin
        stop = (first + rnd > cba_pkg::NUM_BLOCKS) ? cba_pkg::NUM_BLOCKS : first + rnd;
        for (int i = first; i < stop; i++) begin
          tag_store[i] = cba_pkg::TAG_EMPTY;
        end
        r.status = cba_pkg::ST_DONE;
      end
    end
    return r;
  endfunction

  // Send one request, with an optional idle gap carrying junk payload
  task automatic send_request(request_t rq);
    rsp_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do begin
        req_if.operation    <= 1'($urandom_range(1));
        req_if.owner_id     <= cba_pkg::OWNER_W'($urandom_range(255));
        req_if.request_size <= cba_pkg::SIZE_W'($urandom_range(127));
        req_if.start_block  <= cba_pkg::START_W'($urandom_range(63));
        @(posedge clk_i);
      end while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= rq.op;
    req_if.owner_id     <= rq.owner;
    req_if.request_size <= rq.size;
    req_if.start_block  <= rq.start;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    r = apply_request(rq);
    expected_rsp_q.push_back(r);
    if (rq.op == cba_pkg::OP_ALLOC && r.status == cba_pkg::ST_DONE && rq.size != '0) begin
      lease_q.push_back('{owner: rq.owner, size: rq.size});
    end
  endtask

  // Pick a request: mostly fitting allocations and frees of live owners
  task automatic pick_request(output request_t rq);
    int   pick;
    int   n;
    int   spots [$];
    int   owned [$];
    lease_t ls;
    pick = $urandom_range(99);
    if (pick < 55) begin
      rq.op    = cba_pkg::OP_ALLOC;
      rq.owner = cba_pkg::OWNER_W'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
        rq.size = cba_pkg::SIZE_W'($urandom_range(64, 1));
      end else begin
        rq.size = cba_pkg::SIZE_W'($urandom_range(16, 1));
      end
      for (int s = 0; s < cba_pkg::NUM_BLOCKS; s++) begin
        if (range_empty(s, pow2_ceil(rq.size))) begin
          spots.push_back(s);
        end
      end
      if (spots.size() > 0 && $urandom_range(9) < 7) begin
        rq.start = cba_pkg::START_W'(spots[$urandom_range(spots.size() - 1)]);
      end else begin
        rq.start = cba_pkg::START_W'($urandom_range(cba_pkg::NUM_BLOCKS - 1));
      end
    end else if (pick < 88 && lease_q.size() > 0) begin
      n  = $urandom_range(lease_q.size() - 1);
      ls = lease_q[n];
      lease_q.delete(n);
      rq.op    = cba_pkg::OP_FREE;
      rq.owner = ls.owner;
      rq.size  = ($urandom_range(3) == 0) ? cba_pkg::SIZE_W'($urandom_range(16, 1)) : ls.size;
      rq.start = cba_pkg::START_W'($urandom_range(63));
    end else if (pick < 95) begin
      // Free whatever owner sits on a random used block, to clear leftovers
      for (int i = 0; i < cba_pkg::NUM_BLOCKS; i++) begin
        if (tag_store[i][cba_pkg::TAG_W-1:cba_pkg::OWNER_W] == '0) begin
          owned.push_back(i);
        end
      end
      rq.op    = cba_pkg::OP_FREE;
      rq.owner = (owned.size() > 0)
               ? cba_pkg::OWNER_W'(tag_store[owned[$urandom_range(owned.size() - 1)]])
               : cba_pkg::OWNER_W'($urandom_range(255));
      rq.size  = cba_pkg::SIZE_W'($urandom_range(64, 1));
      rq.start = cba_pkg::START_W'($urandom_range(63));
    end else begin
      rq.op    = cba_pkg::op_e'($urandom_range(1));
      rq.owner = cba_pkg::OWNER_W'($urandom_range(255));
      rq.size  = cba_pkg::SIZE_W'($urandom_range(127));
      rq.start = cba_pkg::START_W'($urandom_range(63));
    end
  endtask

  // Stall the response side and check each response against the oldest one expected
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response status %0d rounded %0d", $time,
                   rsp_if.status, rsp_if.rounded_blocks);
          error_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                     rsp_if.status);
            error_count++;
          end
          if (rsp_if.rounded_blocks !== exp_rsp.rounded) begin
            $display("%0t: rounded_blocks expected %0d actual %0d", $time,
                     exp_rsp.rounded, rsp_if.rounded_blocks);
            error_count++;
          end
        end
      end
    end
  end

  // Extremes of every field and each corner of allocate and free
  task automatic test_directed_cases();
    send_request('{cba_pkg::OP_FREE,  8'd5,   7'd1,   6'd0});   // free on an empty store
    send_request('{cba_pkg::OP_ALLOC, 8'd0,   7'd1,   6'd0});
    send_request('{cba_pkg::OP_ALLOC, 8'd255, 7'd64,  6'd0});   // overlaps block 0
    send_request('{cba_pkg::OP_ALLOC, 8'hAA,  7'd3,   6'd4});   // rounds to 4, one pad block
    send_request('{cba_pkg::OP_ALLOC, 8'd1,   7'd0,   6'd10});  // zero size
    send_request('{cba_pkg::OP_ALLOC, 8'd2,   7'd127, 6'd0});   // rounds to 128
    send_request('{cba_pkg::OP_ALLOC, 8'd2,   7'd65,  6'd0});
    send_request('{cba_pkg::OP_ALLOC, 8'h55,  7'd2,   6'd63});  // runs past the end
    send_request('{cba_pkg::OP_ALLOC, 8'h55,  7'd5,   6'd62});
    send_request('{cba_pkg::OP_FREE,  8'hAA,  7'd0,   6'd0});   // found, clears nothing
    send_request('{cba_pkg::OP_ALLOC, 8'd7,   7'd8,   6'd8});
    send_request('{cba_pkg::OP_FREE,  8'hAA,  7'd8,   6'd0});   // clears into owner 7 too
    send_request('{cba_pkg::OP_FREE,  8'd7,   7'd1,   6'd63});
    send_request('{cba_pkg::OP_ALLOC, 8'h7F,  7'd32,  6'd32});
    send_request('{cba_pkg::OP_FREE,  8'h7F,  7'd127, 6'd0});   // clamp at the end
    send_request('{cba_pkg::OP_FREE,  8'd0,   7'd64,  6'd0});
    send_request('{cba_pkg::OP_ALLOC, 8'd255, 7'd64,  6'd0});   // whole store
    send_request('{cba_pkg::OP_ALLOC, 8'd3,   7'd1,   6'd63});
    send_request('{cba_pkg::OP_FREE,  8'd255, 7'd64,  6'd63});
    send_request('{cba_pkg::OP_FREE,  8'd255, 7'd1,   6'd0});   // owner 255 holds no block
    send_request('{cba_pkg::OP_ALLOC, 8'h80,  7'd1,   6'd63});
    send_request('{cba_pkg::OP_FREE,  8'h80,  7'd100, 6'd21});
    send_request('{cba_pkg::OP_ALLOC, 8'd1,   7'd64,  6'd1});
    send_request('{cba_pkg::OP_FREE,  8'd7,   7'd2,   6'd42});
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    request_t rq;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) begin
      pick_request(rq);
      send_request(rq);
    end
  endtask

  initial begin
    int waited;
    for (int i = 0; i < cba_pkg::NUM_BLOCKS; i++) begin
      tag_store[i] = cba_pkg::TAG_EMPTY;
    end
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.operation    <= cba_pkg::OP_ALLOC;
    req_if.owner_id     <= '0;
    req_if.request_size <= '0;
    req_if.start_block  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(400, 0, 0);
    test_random_traffic(350, 78, 0);
    test_random_traffic(350, 0, 78);
    test_random_traffic(400, 10, 10);

    // Drop valid and let the remaining responses drain
    req_if.valid <= 1'b0;
    waited = 0;
    while (expected_rsp_q.size() > 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_rsp_q.size() > 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
      error_count++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
